### hdl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

    // frame layout
    localparam int FRAME_BYTES = 24;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int NUM_CH      = 16;
    localparam int CH_BITS     = 11;
    localparam int CH_IDX_W    = $clog2(NUM_CH);

    // field widths
    localparam int IDLE_W      = 20;
    localparam int SCALE_W     = 18;
    localparam int CAL_W       = 32;
    localparam int PROD_W      = CH_BITS + 1 + SCALE_W;
    localparam int SUM_W       = CAL_W + 2;
    localparam int LOST_W      = 16;
    localparam int NIB_W       = 4;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_BIAS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_BYTE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_NIBBLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_MASK    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FS_MASK      = 3'd7;

    // register reset values
    localparam logic [IDLE_W-1:0]         RST_IDLE_TIMEOUT = 20'd7000;
    localparam logic signed [SCALE_W-1:0] RST_CAL_SCALE    = 18'sd20471;
    localparam logic signed [CAL_W-1:0]   RST_CAL_BIAS     = -32'sd20298754;
    localparam logic [7:0]                RST_HEADER_BYTE  = 8'h0F;
    localparam logic [7:0]                RST_FOOTER_BYTE  = 8'h00;
    localparam logic [NIB_W-1:0]          RST_ALT_NIBBLE   = 4'd4;
    localparam logic [7:0]                RST_LOST_MASK    = 8'h04;
    localparam logic [7:0]                RST_FS_MASK      = 8'h08;

    // input word codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CH - 1);

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [CH_IDX_W-1:0]     channel_index;
        logic [CH_BITS-1:0]      channel_raw;
        logic signed [CAL_W-1:0] channel_cal;
        logic                    failsafe;
        logic                    lost_frame;
        logic [LOST_W-1:0]       lost_frame_count;
        logic                    last;
    } t_out_word;

endpackage
`default_nettype wire

### hdl/sbus_frame_decoder_core.sv
// Channel   Direction  Handshake                    Word
// in        input      i_in_valid / o_in_ready      i_in  (t_in_word: action, rx_byte)
// out       output     o_out_valid / i_out_ready    o_out (t_out_word: one channel)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A byte or tick word is taken while the sequencer is idle, and framed as it is taken.
// A good frame then runs the shared multiply/add unit, S_MUL then S_ADD, for each
// of the 16 channel words; S_ADD waits on a stalled out; input is held off meanwhile.
// The last channel word may still wait in the output register while input resumes.
// Reset (synchronous, active low) clears framing, counters and the sequencer and
// loads the configuration defaults; the frame shift register is never cleared.
// cfg is always ready; writes are expected only while the block is idle.
`default_nettype none
module sbus_frame_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sfd_pkg::t_in_word                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sfd_pkg::t_out_word                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sfd_pkg::*;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;   // taking bytes and ticks
    localparam logic [1:0] S_MUL  = 2'd1;   // raw * scale into r_prod
    localparam logic [1:0] S_ADD  = 2'd2;   // + bias, saturate, load output

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // configuration registers
    logic [IDLE_W-1:0]         r_idle_timeout;
    logic signed [SCALE_W-1:0] r_cal_scale;
    logic signed [CAL_W-1:0]   r_cal_bias;
    logic [7:0]                r_header;
    logic [7:0]                r_footer;
    logic [NIB_W-1:0]          r_alt_nib;
    logic [7:0]                r_lost_mask;
    logic [7:0]                r_fs_mask;

    // control state
    logic [1:0]          r_state,    n_state;
    logic [POS_W-1:0]    r_pos,      n_pos;
    logic [7:0]          r_prev,     n_prev;
    logic [IDLE_W-1:0]   r_idle,     n_idle;
    logic [LOST_W-1:0]   r_lost_cnt, n_lost_cnt;
    logic [CH_IDX_W-1:0] r_cnt,      n_cnt;
    logic                r_out_valid, n_out_valid;

    // data path
    logic [FRAME_BITS-1:0]    r_frame, n_frame;
    logic                     r_fs,    n_fs;
    logic                     r_lf,    n_lf;
    logic [CH_BITS-1:0]       r_raw,   n_raw;
    logic signed [PROD_W-1:0] r_prod,  n_prod;
    t_out_word                r_out,   n_out;

    logic                    in_acc;
    logic                    prev_is_footer;
    logic                    rx_is_footer;
    logic                    good;
    logic [7:0]              flags;
    logic signed [SUM_W-1:0] sum;
    logic signed [CAL_W-1:0] cal_sat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc = i_in_valid && o_in_ready;

    // footer test: exact footer byte or SBUS2 low nibble
    assign prev_is_footer = (r_prev == r_footer) || (r_prev[NIB_W-1:0] == r_alt_nib);
    assign rx_is_footer   = (i_in.rx_byte == r_footer)
                         || (i_in.rx_byte[NIB_W-1:0] == r_alt_nib);

    // newest stored byte is the flag byte when the footer arrives
    assign flags = r_frame[FRAME_BITS-1 -: 8];

    // shared add and saturate stage
    assign sum = SUM_W'(r_prod) + SUM_W'(r_cal_bias);

    always_comb begin
        if (!sum[SUM_W-1] && (sum[SUM_W-2:CAL_W-1] != '0)) begin
            cal_sat = {1'b0, {(CAL_W-1){1'b1}}};
        end else if (sum[SUM_W-1] && (sum[SUM_W-2:CAL_W-1] != '1)) begin
            cal_sat = {1'b1, {(CAL_W-1){1'b0}}};
        end else begin
            cal_sat = sum[CAL_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_idle      = r_idle;
        n_lost_cnt  = r_lost_cnt;
        n_cnt       = r_cnt;
        n_frame     = r_frame;
        n_fs        = r_fs;
        n_lf        = r_lf;
        n_raw       = r_raw;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        good        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == ACT_TICK) begin
                        if (r_idle != IDLE_MAX) begin
                            n_idle = r_idle + 1'b1;
                        end
                        if (n_idle > r_idle_timeout) begin
                            n_pos = '0;
                        end
                    end else begin
                        n_idle = '0;
                        n_prev = i_in.rx_byte;
                        if (r_pos == '0) begin
                            if ((i_in.rx_byte == r_header) && prev_is_footer) begin
                                n_pos = POS_W'(1);
                            end
                        end else begin
                            // bytes enter at the top; byte 0 ends at the bottom
                            n_frame = {i_in.rx_byte, r_frame[FRAME_BITS-1:8]};
                            if (r_pos == POS_W'(FRAME_BYTES)) begin
                                n_pos = '0;
                                good  = rx_is_footer;
                            end else begin
                                n_pos = r_pos + 1'b1;
                            end
                        end
                    end
                end
                if (good) begin
                    n_fs  = |(flags & r_fs_mask);
                    n_lf  = |(flags & r_lost_mask);
                    if (n_lf) begin
                        n_lost_cnt = r_lost_cnt + 1'b1;
                    end
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_raw   = r_frame[CH_BITS-1:0];
                n_prod  = $signed({1'b0, r_frame[CH_BITS-1:0]}) * r_cal_scale;
                n_frame = r_frame >> CH_BITS;
                n_state = S_ADD;
            end
            S_ADD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.channel_index    = r_cnt;
                    n_out.channel_raw      = r_raw;
                    n_out.channel_cal      = cal_sat;
                    n_out.failsafe         = r_fs;
                    n_out.lost_frame       = r_lf;
                    n_out.lost_frame_count = r_lost_cnt;
                    n_out.last             = (r_cnt == LAST_CH);
                    n_out_valid            = 1'b1;
                    n_cnt                  = r_cnt + 1'b1;
                    n_state                = (r_cnt == LAST_CH) ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_prev      <= '0;
            r_idle      <= '0;
            r_lost_cnt  <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_prev      <= n_prev;
            r_idle      <= n_idle;
            r_lost_cnt  <= n_lost_cnt;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_fs    <= n_fs;
        r_lf    <= n_lf;
        r_raw   <= n_raw;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= RST_IDLE_TIMEOUT;
            r_cal_scale    <= RST_CAL_SCALE;
            r_cal_bias     <= RST_CAL_BIAS;
            r_header       <= RST_HEADER_BYTE;
            r_footer       <= RST_FOOTER_BYTE;
            r_alt_nib      <= RST_ALT_NIBBLE;
            r_lost_mask    <= RST_LOST_MASK;
            r_fs_mask      <= RST_FS_MASK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[IDLE_W-1:0];
                REG_CAL_SCALE:    r_cal_scale    <= i_cfg_data[SCALE_W-1:0];
                REG_CAL_BIAS:     r_cal_bias     <= i_cfg_data[CAL_W-1:0];
                REG_HEADER_BYTE:  r_header       <= i_cfg_data[7:0];
                REG_FOOTER_BYTE:  r_footer       <= i_cfg_data[7:0];
                REG_ALT_NIBBLE:   r_alt_nib      <= i_cfg_data[NIB_W-1:0];
                REG_LOST_MASK:    r_lost_mask    <= i_cfg_data[7:0];
                REG_FS_MASK:      r_fs_mask      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/sfd_checker.sv
`default_nettype none
module sfd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input sfd_pkg::t_in_word                  i_in,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input sfd_pkg::t_out_word                 o_out
);
    import sfd_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output word changed under stall");

    // last flag only on the final channel
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last) |-> (o_out.channel_index == LAST_CH))
        else $error("last set on wrong channel");

    // no input taken while a frame is still being emitted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |-> !o_in_ready)
        else $error("input ready mid-frame");

    // a tick never starts output
    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in.action == ACT_TICK) && !o_out_valid)
        |=> !o_out_valid)
        else $error("output after tick");

    // lost count fixed within a frame
    a_lost_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last) |=> $stable(o_out.lost_frame_count))
        else $error("lost count changed mid-frame");

endmodule

bind sbus_frame_decoder_core sfd_checker u_sfd_checker (.*);
`default_nettype wire
